// ===== rtl/lldq_pkg.sv =====
package lldq_pkg;

  localparam int NODES    = 256;
  localparam int NODE_W   = $clog2(NODES);
  localparam int COUNT_W  = $clog2(NODES + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REMOVE     = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_HANDLE = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic decode;
    logic push_take;
    logic push_link;
    logic unlink_links;
    logic unlink_single;
    logic unlink_val;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    status_e err;
    logic    is_push;
    logic    is_unlink;
    logic    single;
    logic    empty;
  } dp_stat_t;

endpackage

// ===== rtl/lldq_intf.sv =====
interface lldq_req_if;
  logic                               valid;
  logic                               ready;
  logic [lldq_pkg::REQ_W-1:0]         req_type;
  logic signed [lldq_pkg::DATA_W-1:0] value;
  logic [lldq_pkg::HANDLE_W-1:0]      handle;

  modport source (output valid, req_type, value, handle, input ready);
  modport sink (input valid, req_type, value, handle, output ready);
endinterface

interface lldq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [lldq_pkg::STATUS_W-1:0]      status;
  logic signed [lldq_pkg::DATA_W-1:0] data;
  logic [lldq_pkg::HANDLE_W-1:0]      out_handle;
  logic                               next_valid;
  logic signed [lldq_pkg::DATA_W-1:0] front_value;
  logic signed [lldq_pkg::DATA_W-1:0] back_value;
  logic [lldq_pkg::COUNT_W-1:0]       item_total;
  logic                               is_empty;

  modport source (output valid, status, data, out_handle, next_valid, front_value,
                  back_value, item_total, is_empty, input ready);
  modport sink (input valid, status, data, out_handle, next_valid, front_value,
                back_value, item_total, is_empty, output ready);
endinterface

// ===== rtl/lldq_ctrl.sv =====
module lldq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  lldq_pkg::dp_stat_t stat_i,
  output lldq_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE         = 3'd0;
  localparam logic [2:0] S_DECODE       = 3'd1;
  localparam logic [2:0] S_PUSH_TAKE    = 3'd2;
  localparam logic [2:0] S_PUSH_LINK    = 3'd3;
  localparam logic [2:0] S_UNLINK_LINKS = 3'd4;
  localparam logic [2:0] S_UNLINK_VAL   = 3'd5;
  localparam logic [2:0] S_DONE         = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (stat_i.err != lldq_pkg::ST_OK) begin
          state_d = S_DONE;
        end else if (stat_i.is_push) begin
          state_d = S_PUSH_TAKE;
        end else if (stat_i.is_unlink) begin
          if (stat_i.single) begin
            cmd_o.unlink_single = 1'b1;
            state_d             = S_DONE;
          end else begin
            state_d = S_UNLINK_LINKS;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_PUSH_TAKE: begin
        cmd_o.push_take = 1'b1;
        state_d         = stat_i.empty ? S_DONE : S_PUSH_LINK;
      end
      S_PUSH_LINK: begin
        cmd_o.push_link = 1'b1;
        state_d         = S_DONE;
      end
      S_UNLINK_LINKS: begin
        cmd_o.unlink_links = 1'b1;
        state_d            = S_UNLINK_VAL;
      end
      S_UNLINK_VAL: begin
        cmd_o.unlink_val = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// ===== rtl/lldq_datapath.sv =====
module lldq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lldq_pkg::dp_cmd_t                   cmd_i,
  output lldq_pkg::dp_stat_t                  stat_o,
  input  logic [lldq_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [lldq_pkg::DATA_W-1:0]  value_i,
  input  logic [lldq_pkg::HANDLE_W-1:0]       handle_i,
  output logic [lldq_pkg::STATUS_W-1:0]       status_o,
  output logic signed [lldq_pkg::DATA_W-1:0]  data_o,
  output logic [lldq_pkg::HANDLE_W-1:0]       out_handle_o,
  output logic                                next_valid_o,
  output logic signed [lldq_pkg::DATA_W-1:0]  front_value_o,
  output logic signed [lldq_pkg::DATA_W-1:0]  back_value_o,
  output logic [lldq_pkg::COUNT_W-1:0]        item_total_o,
  output logic                                is_empty_o
);

  // Link, value and free-node memories.
  logic [lldq_pkg::NODE_W-1:0] next_mem  [lldq_pkg::NODES];
  logic [lldq_pkg::NODE_W-1:0] prev_mem  [lldq_pkg::NODES];
  logic [lldq_pkg::DATA_W-1:0] val_mem   [lldq_pkg::NODES];
  logic [lldq_pkg::NODE_W-1:0] stack_mem [lldq_pkg::NODES];

  logic [lldq_pkg::NODE_W-1:0] next_rd_q, prev_rd_q, stack_rd_q;
  logic [lldq_pkg::DATA_W-1:0] val_rd_q;

  // Control state.
  logic [lldq_pkg::NODES-1:0]   in_list_q;
  logic [lldq_pkg::NODE_W-1:0]  head_q, tail_q;
  logic [lldq_pkg::COUNT_W-1:0] count_q, free_top_q, low_q;

  // Request and working registers.
  logic [lldq_pkg::REQ_W-1:0]    req_type_q;
  logic [lldq_pkg::DATA_W-1:0]   value_q;
  logic [lldq_pkg::HANDLE_W-1:0] handle_q;
  logic [lldq_pkg::DATA_W-1:0]   front_q, back_q;
  logic [lldq_pkg::NODE_W-1:0]   n_q;
  logic                          was_head_q, was_tail_q;
  logic [lldq_pkg::STATUS_W-1:0] res_status_q;
  logic [lldq_pkg::DATA_W-1:0]   res_data_q;
  logic [lldq_pkg::HANDLE_W-1:0] res_oh_q;
  logic                          res_nv_q;

  // Output register.
  logic [lldq_pkg::STATUS_W-1:0] out_status_q;
  logic [lldq_pkg::DATA_W-1:0]   out_data_q, out_front_q, out_back_q;
  logic [lldq_pkg::HANDLE_W-1:0] out_oh_q;
  logic                          out_nv_q, out_empty_q;
  logic [lldq_pkg::COUNT_W-1:0]  out_total_q;

  logic                         is_push, is_pop, is_remove, is_front, release_node;
  logic                         handle_ok;
  logic [lldq_pkg::NODE_W-1:0]  tgt, take_node, val_raddr;
  logic [lldq_pkg::COUNT_W-1:0] stack_idx;
  lldq_pkg::status_e            err;

  logic                         next_we, prev_we, val_we;
  logic [lldq_pkg::NODE_W-1:0]  next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign is_push   = (req_type_q == lldq_pkg::REQ_PUSH_FRONT) ||
                     (req_type_q == lldq_pkg::REQ_PUSH_BACK);
  assign is_pop    = (req_type_q == lldq_pkg::REQ_POP_FRONT) ||
                     (req_type_q == lldq_pkg::REQ_POP_BACK);
  assign is_remove = (req_type_q == lldq_pkg::REQ_REMOVE);
  assign is_front  = (req_type_q == lldq_pkg::REQ_PUSH_FRONT);
  assign handle_ok = (32'(handle_q) < 32'(lldq_pkg::NODES)) &&
                     in_list_q[handle_q[lldq_pkg::NODE_W-1:0]];

  assign release_node = cmd_i.unlink_links || cmd_i.unlink_single;

  always_comb begin
    case (req_type_q)
      lldq_pkg::REQ_POP_FRONT: tgt = head_q;
      lldq_pkg::REQ_POP_BACK:  tgt = tail_q;
      default:                 tgt = handle_q[lldq_pkg::NODE_W-1:0];
    endcase
  end

  always_comb begin
    err = lldq_pkg::ST_OK;
    if (is_push) begin
      if (free_top_q == '0) begin
        err = lldq_pkg::ST_FULL;
      end
    end else if (is_pop || is_remove) begin
      if (count_q == '0) begin
        err = lldq_pkg::ST_EMPTY;
      end else if (is_remove && !handle_ok) begin
        err = lldq_pkg::ST_NO_HANDLE;
      end
    end
  end

  assign stat_o.err       = err;
  assign stat_o.is_push   = is_push;
  assign stat_o.is_unlink = is_pop || is_remove;
  assign stat_o.single    = (count_q == lldq_pkg::COUNT_W'(1));
  assign stat_o.empty     = (count_q == '0);

  // Stack entries below the lowest level ever reached were never written, so their
  // own index is used in place of the memory contents.
  assign stack_idx = free_top_q - lldq_pkg::COUNT_W'(1);
  assign take_node = (stack_idx < low_q) ? stack_idx[lldq_pkg::NODE_W-1:0] : stack_rd_q;

  // After unlinking, only the end that moved needs a new value.
  assign val_raddr = (tgt == head_q) ? next_rd_q : prev_rd_q;

  always_comb begin
    next_we    = 1'b0;
    next_waddr = take_node;
    next_wdata = head_q;
    prev_we    = 1'b0;
    prev_waddr = take_node;
    prev_wdata = tail_q;
    val_we     = cmd_i.push_take;
    if (cmd_i.push_take) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      if (count_q == '0) begin
        next_wdata = take_node;
        prev_wdata = take_node;
      end
    end else if (cmd_i.push_link) begin
      next_we    = 1'b1;
      next_waddr = tail_q;
      next_wdata = n_q;
      prev_we    = 1'b1;
      prev_waddr = head_q;
      prev_wdata = n_q;
    end else if (cmd_i.unlink_links) begin
      next_we    = 1'b1;
      next_waddr = prev_rd_q;
      next_wdata = next_rd_q;
      prev_we    = 1'b1;
      prev_waddr = next_rd_q;
      prev_wdata = prev_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_q <= next_mem[tgt];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_q <= prev_mem[tgt];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[take_node] <= value_q;
    end
    val_rd_q <= val_mem[val_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (release_node) begin
      stack_mem[free_top_q[lldq_pkg::NODE_W-1:0]] <= tgt;
    end
    stack_rd_q <= stack_mem[stack_idx[lldq_pkg::NODE_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_list_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      free_top_q <= lldq_pkg::COUNT_W'(lldq_pkg::NODES);
      low_q      <= lldq_pkg::COUNT_W'(lldq_pkg::NODES);
    end else begin
      if (cmd_i.push_take) begin
        in_list_q[take_node] <= 1'b1;
        free_top_q           <= stack_idx;
        if (stack_idx < low_q) begin
          low_q <= stack_idx;
        end
        if (count_q == '0) begin
          head_q  <= take_node;
          tail_q  <= take_node;
          count_q <= lldq_pkg::COUNT_W'(1);
        end
      end
      if (cmd_i.push_link) begin
        count_q <= count_q + lldq_pkg::COUNT_W'(1);
        if (is_front) begin
          head_q <= n_q;
        end else begin
          tail_q <= n_q;
        end
      end
      if (release_node) begin
        in_list_q[tgt] <= 1'b0;
        free_top_q     <= free_top_q + lldq_pkg::COUNT_W'(1);
      end
      if (cmd_i.unlink_links) begin
        count_q <= count_q - lldq_pkg::COUNT_W'(1);
        if (tgt == head_q) begin
          head_q <= next_rd_q;
        end
        if (tgt == tail_q) begin
          tail_q <= prev_rd_q;
        end
      end
      if (cmd_i.unlink_single) begin
        count_q <= '0;
        head_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      value_q    <= value_i;
      handle_q   <= handle_i;
    end
    if (cmd_i.push_take) begin
      n_q <= take_node;
      if (count_q == '0) begin
        front_q <= value_q;
        back_q  <= value_q;
      end
    end
    if (cmd_i.push_link) begin
      if (is_front) begin
        front_q <= value_q;
      end else begin
        back_q <= value_q;
      end
    end
    if (cmd_i.unlink_links) begin
      was_head_q <= (tgt == head_q);
      was_tail_q <= (tgt == tail_q);
    end
    if (cmd_i.unlink_val) begin
      if (was_head_q) begin
        front_q <= val_rd_q;
      end else if (was_tail_q) begin
        back_q <= val_rd_q;
      end
    end

    if (cmd_i.decode) begin
      res_status_q <= err;
      res_data_q   <= '0;
      res_oh_q     <= '0;
      res_nv_q     <= 1'b0;
    end
    if (cmd_i.push_take) begin
      res_oh_q <= lldq_pkg::HANDLE_W'(take_node);
      res_nv_q <= 1'b1;
    end
    if (release_node) begin
      if (req_type_q == lldq_pkg::REQ_POP_FRONT) begin
        res_data_q <= front_q;
      end else if (req_type_q == lldq_pkg::REQ_POP_BACK) begin
        res_data_q <= back_q;
      end
    end
    if (cmd_i.unlink_links && is_remove && (tgt != head_q)) begin
      res_oh_q <= lldq_pkg::HANDLE_W'(next_rd_q);
      res_nv_q <= 1'b1;
    end

    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_oh_q     <= res_oh_q;
      out_nv_q     <= res_nv_q;
      out_front_q  <= (count_q != '0) ? front_q : '0;
      out_back_q   <= (count_q != '0) ? back_q : '0;
      out_total_q  <= count_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  assign status_o      = out_status_q;
  assign data_o        = out_data_q;
  assign out_handle_o  = out_oh_q;
  assign next_valid_o  = out_nv_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;
  assign item_total_o  = out_total_q;
  assign is_empty_o    = out_empty_q;

endmodule

// ===== rtl/linked_list_deque_engine_top.sv =====
// Circular doubly linked list over a pool of 256 nodes. Each request item pushes a
// value at the front or back (the result gives the node handle taken), pops at the
// front or back (the result gives the value), or removes a node by handle (the
// result gives the handle of the following node, or none when the head was removed).
// Every result also carries the front and back values, the node count and an empty
// flag after the request. A request that cannot be served (empty list, full pool,
// handle not in the list) returns an error status and leaves the list unchanged.
// The block takes one item at a time: after decode, an error, an ignored request
// code, or a pop or remove on a one-node list goes straight to the done state; a
// push takes a node and, on a non-empty list, links it in; any other pop or remove
// unlinks the node. These steps follow from the link memories with one read and one
// write port and registered reads: unlinking reads both neighbor links, rewrites
// them and then reads the value of the new end node.
// A new item is accepted while the previous result still waits in the output
// register. No memory clearing pass is needed after reset.
module linked_list_deque_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lldq_req_if.sink   req_i,
  lldq_rsp_if.source rsp_o
);

  lldq_pkg::dp_cmd_t  cmd;
  lldq_pkg::dp_stat_t stat;

  lldq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lldq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_i.req_type),
    .value_i       (req_i.value),
    .handle_i      (req_i.handle),
    .status_o      (rsp_o.status),
    .data_o        (rsp_o.data),
    .out_handle_o  (rsp_o.out_handle),
    .next_valid_o  (rsp_o.next_valid),
    .front_value_o (rsp_o.front_value),
    .back_value_o  (rsp_o.back_value),
    .item_total_o  (rsp_o.item_total),
    .is_empty_o    (rsp_o.is_empty)
  );

endmodule
